@@ sv/sfei_pkg.sv @@
// ----------------------------------------------------------------------------
// sfei_pkg
// Types and constants shared by the spanning forest edge insert block.
// ----------------------------------------------------------------------------
package sfei_pkg;

  localparam int unsigned PeakW   = 10;
  localparam int unsigned SidW    = 12;
  localparam int unsigned HeightW = 32;

  // result codes
  typedef enum logic [1:0] {
    OC_LINKED   = 2'd0,
    OC_DISCARD  = 2'd1,
    OC_REPLACED = 2'd2
  } outcome_e;

  typedef struct packed {
    logic        [PeakW-1:0]   first_peak;
    logic        [PeakW-1:0]   second_peak;
    logic        [SidW-1:0]    new_saddle_id;
    logic signed [HeightW-1:0] new_saddle_height;
  } in_beat_t;

  typedef struct packed {
    outcome_e              outcome;
    logic     [SidW-1:0]   dropped_saddle_id;
  } out_beat_t;

  // one forest node: link to parent and the saddle on that edge
  typedef struct packed {
    logic        [PeakW-1:0]   parent;
    logic        [SidW-1:0]    saddle;
    logic signed [HeightW-1:0] height;
  } node_t;

  // write port of the node store
  typedef struct packed {
    logic             en;
    logic [PeakW-1:0] addr;
    node_t            data;
  } wr_t;

endpackage

@@ sv/spanning_forest_edge_insert_top.sv @@
// Operation: walks each peak's parent chain to its root; for peaks in one
// tree, climbs both chains toward the meeting point; to link or swap,
// reverses edges while re-rooting the first tree.
// Throughput: one insert at a time; in_ready_o is high only while idle.
// Reset: control clears at once; then a clearing pass zeroes the store,
// during which in_ready_o stays low.
// ----------------------------------------------------------------------------
// spanning_forest_edge_insert_top
// Online maximum spanning forest: links, discards or swaps one saddle edge
// per input beat, walking parent chains through a shared node store.
// ----------------------------------------------------------------------------
module spanning_forest_edge_insert_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfei_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfei_pkg::out_beat_t out_beat_o
);

  localparam int unsigned PW = sfei_pkg::PeakW;
  localparam int unsigned SW = sfei_pkg::SidW;
  localparam int unsigned HW = sfei_pkg::HeightW;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_DA_RD, ST_DA_USE, ST_DB_RD, ST_DB_USE,
    ST_MEET, ST_WA_RD, ST_WA_USE, ST_WB_RD, ST_WB_USE,
    ST_DECIDE,
    ST_MR0_RD, ST_MR0_USE, ST_MR_RD, ST_MR_USE,
    ST_LINK, ST_DONE
  } state_e;

  state_e              state_q;
  logic [PW-1:0]       clr_q;
  logic [PW-1:0]       a_q, b_q, cur_q, root_a_q, pa_q, pb_q;
  logic [PW-1:0]       cnt_q, da_q, db_q;
  logic [SW-1:0]       sid_q;
  logic signed [HW-1:0] h_q;
  logic                has_a_q, has_b_q;
  logic [PW-1:0]       best_a_q, best_b_q;
  logic signed [HW-1:0] best_a_h_q, best_b_h_q;
  logic [SW-1:0]       best_a_s_q, best_b_s_q;
  logic [PW-1:0]       child_q, p_q;
  logic [SW-1:0]       msid_q;
  logic signed [HW-1:0] mh_q;
  sfei_pkg::outcome_e  oc_q;
  logic [SW-1:0]       drop_q;
  logic                out_valid_q;
  sfei_pkg::out_beat_t out_beat_q;

  sfei_pkg::wr_t       wr;
  logic [PW-1:0]       rd_addr;
  sfei_pkg::node_t     rd;

  logic                use_b_side;
  logic [PW-1:0]       low_node;
  logic signed [HW-1:0] low_h;
  logic [SW-1:0]       low_s;

  sfei_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd)
  );

  // lowest edge on the cycle: first peak's side wins ties
  always_comb begin
    use_b_side = !has_a_q || (has_b_q && (best_b_h_q < best_a_h_q));
    low_node   = use_b_side ? best_b_q   : best_a_q;
    low_h      = use_b_side ? best_b_h_q : best_a_h_q;
    low_s      = use_b_side ? best_b_s_q : best_a_s_q;
  end

  // store read address
  always_comb begin
    case (state_q)
      ST_WA_RD:  rd_addr = pa_q;
      ST_WB_RD:  rd_addr = pb_q;
      ST_MR0_RD: rd_addr = a_q;
      ST_MR_RD:  rd_addr = p_q;
      default:   rd_addr = cur_q;
    endcase
  end

  // store write port
  always_comb begin
    wr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_q;
      end
      ST_DECIDE: begin
        wr.en   = !(h_q < low_h);
        wr.addr = low_node;
      end
      ST_MR_USE: begin
        wr.en          = 1'b1;
        wr.addr        = p_q;
        wr.data.parent = child_q;
        wr.data.saddle = msid_q;
        wr.data.height = mh_q;
      end
      ST_LINK: begin
        wr.en          = 1'b1;
        wr.addr        = a_q;
        wr.data.parent = b_q;
        wr.data.saddle = sid_q;
        wr.data.height = h_q;
      end
      default: wr = '0;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            a_q   <= in_beat_i.first_peak;
            b_q   <= in_beat_i.second_peak;
            sid_q <= in_beat_i.new_saddle_id;
            h_q   <= in_beat_i.new_saddle_height;
            cur_q <= in_beat_i.first_peak;
            cnt_q <= '0;
            oc_q  <= sfei_pkg::OC_DISCARD;
            drop_q <= in_beat_i.new_saddle_id;
            if (in_beat_i.first_peak == '0 || in_beat_i.second_peak == '0 ||
                in_beat_i.first_peak == in_beat_i.second_peak) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_DA_RD;
            end
          end
        end
        // depth and root of the first peak
        ST_DA_RD: state_q <= ST_DA_USE;
        ST_DA_USE: begin
          if (rd.parent == '0) begin
            da_q     <= cnt_q;
            root_a_q <= cur_q;
            cur_q    <= b_q;
            cnt_q    <= '0;
            state_q  <= ST_DB_RD;
          end else begin
            cur_q   <= rd.parent;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_DA_RD;
          end
        end
        // depth and root of the second peak
        ST_DB_RD: state_q <= ST_DB_USE;
        ST_DB_USE: begin
          if (rd.parent == '0) begin
            db_q    <= cnt_q;
            pa_q    <= a_q;
            pb_q    <= b_q;
            has_a_q <= 1'b0;
            has_b_q <= 1'b0;
            if (cur_q != root_a_q) begin
              oc_q    <= sfei_pkg::OC_LINKED;
              drop_q  <= '0;
              state_q <= ST_MR0_RD;
            end else begin
              state_q <= ST_MEET;
            end
          end else begin
            cur_q   <= rd.parent;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_DB_RD;
          end
        end
        // climb toward the meeting point
        ST_MEET: begin
          if (da_q > db_q)      state_q <= ST_WA_RD;
          else if (db_q > da_q) state_q <= ST_WB_RD;
          else if (pa_q == pb_q) state_q <= ST_DECIDE;
          else                  state_q <= ST_WA_RD;
        end
        ST_WA_RD: state_q <= ST_WA_USE;
        ST_WA_USE: begin
          if (!has_a_q || (rd.height < best_a_h_q)) begin
            has_a_q    <= 1'b1;
            best_a_q   <= pa_q;
            best_a_h_q <= rd.height;
            best_a_s_q <= rd.saddle;
          end
          pa_q    <= rd.parent;
          da_q    <= da_q - 1'b1;
          state_q <= (da_q == db_q) ? ST_WB_RD : ST_MEET;
        end
        ST_WB_RD: state_q <= ST_WB_USE;
        ST_WB_USE: begin
          if (!has_b_q || (rd.height < best_b_h_q)) begin
            has_b_q    <= 1'b1;
            best_b_q   <= pb_q;
            best_b_h_q <= rd.height;
            best_b_s_q <= rd.saddle;
          end
          pb_q    <= rd.parent;
          db_q    <= db_q - 1'b1;
          state_q <= ST_MEET;
        end
        // keep or swap; the cut itself goes out on the write port
        ST_DECIDE: begin
          if (h_q < low_h) begin
            state_q <= ST_DONE;
          end else begin
            oc_q    <= sfei_pkg::OC_REPLACED;
            drop_q  <= low_s;
            state_q <= ST_MR0_RD;
          end
        end
        // re-root the first peak's tree by reversing its parent chain
        ST_MR0_RD: state_q <= ST_MR0_USE;
        ST_MR0_USE: begin
          child_q <= a_q;
          p_q     <= rd.parent;
          msid_q  <= rd.saddle;
          mh_q    <= rd.height;
          state_q <= (rd.parent == '0) ? ST_LINK : ST_MR_RD;
        end
        ST_MR_RD: state_q <= ST_MR_USE;
        ST_MR_USE: begin
          msid_q  <= rd.saddle;
          mh_q    <= rd.height;
          child_q <= p_q;
          p_q     <= rd.parent;
          state_q <= (rd.parent == '0) ? ST_LINK : ST_MR_RD;
        end
        ST_LINK: state_q <= ST_DONE;
        // hand the result to the output register
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q                  <= 1'b1;
            out_beat_q.outcome           <= oc_q;
            out_beat_q.dropped_saddle_id <= drop_q;
            state_q                      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a link of separate trees drops nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.outcome == sfei_pkg::OC_LINKED
      |-> out_beat_o.dropped_saddle_id == '0)
    else $error("linked result carries a dropped saddle");

  // no input is taken while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o)
    else $error("input taken during clearing pass");

  // a new result is loaded only into a free or draining output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !out_ready_i |=> state_q == ST_DONE)
    else $error("result overwrote a pending beat");
`endif

endmodule

@@ sv/sfei_store.sv @@
// ----------------------------------------------------------------------------
// sfei_store
// Node store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfei_store (
  input  logic                              clk_i,
  input  sfei_pkg::wr_t                     wr_i,
  input  logic [sfei_pkg::PeakW-1:0]        rd_addr_i,
  output sfei_pkg::node_t                   rd_data_o
);

  sfei_pkg::node_t mem_q [2**sfei_pkg::PeakW];
  sfei_pkg::node_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spanning forest edge insert block: a directed
// table, then random edge inserts on small and full peak ranges; each beat
// is checked against a behavioral forest model or a typed row's result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PW = sfei_pkg::PeakW;
  localparam int unsigned SW = sfei_pkg::SidW;
  localparam int unsigned HW = sfei_pkg::HeightW;
  localparam int unsigned NumPeaks = 1 << PW;
  localparam int unsigned RandItems = 1850;
  localparam int unsigned HoldCycles = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sfei_pkg::in_beat_t  in_beat_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sfei_pkg::out_beat_t out_beat_o;

  spanning_forest_edge_insert_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // forest model state
  logic [PW-1:0] fm_parent [NumPeaks];
  logic [SW-1:0] fm_saddle [NumPeaks];
  longint        fm_height [NumPeaks];

  sfei_pkg::out_beat_t pending_results [$];
  int        mismatch_cnt = 0;
  int        send_idle_pct = 36;
  int        recv_idle_pct = 55;
  bit        hold_req = 1'b0;

  typedef struct {
    sfei_pkg::in_beat_t  beat;
    bit                  typed;
    sfei_pkg::out_beat_t res;
  } row_t;
  row_t dir_rows [$];

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned tree_depth(int unsigned n);
    int unsigned d = 0;
    do begin
      d++;
      n = 32'(fm_parent[n]);
    end while (n != 0 && d < NumPeaks);
    return d;
  endfunction

  function automatic int unsigned common_ancestor(int unsigned a, int unsigned b);
    int unsigned da = tree_depth(a);
    int unsigned db = tree_depth(b);
    while (da > db) begin
      a = 32'(fm_parent[a]);
      if (a == 0) break;
      da--;
    end
    while (db > da) begin
      b = 32'(fm_parent[b]);
      if (b == 0) break;
      db--;
    end
    for (int k = 0; k <= NumPeaks; k++) begin
      if (a == 0 || b == 0) return 0;
      if (a == b) return a;
      a = 32'(fm_parent[a]);
      b = 32'(fm_parent[b]);
    end
    return 0;
  endfunction

  function automatic int unsigned weakest_edge(int unsigned c, int unsigned top);
    int unsigned best = c;
    if (c == top) return 0;
    for (int k = 0; k < NumPeaks && c != top; k++) begin
      if (fm_parent[c] == 0) return 0;
      if (fm_height[c] < fm_height[best]) best = c;
      c = 32'(fm_parent[c]);
    end
    return (c == top) ? best : 0;
  endfunction

  // flip the chain above n so n becomes the root
  function automatic void reroot(int unsigned n);
    int unsigned child = n;
    int unsigned p = 32'(fm_parent[n]);
    logic [SW-1:0] sid = fm_saddle[n];
    longint h = fm_height[n];
    int unsigned gp;
    logic [SW-1:0] ts;
    longint th;
    for (int k = 0; k < NumPeaks && p != 0; k++) begin
      gp = 32'(fm_parent[p]);
      ts = fm_saddle[p];
      th = fm_height[p];
      fm_saddle[p] = sid;
      fm_height[p] = h;
      fm_parent[p] = PW'(child);
      sid = ts;
      h = th;
      child = p;
      p = gp;
    end
    fm_parent[n] = '0;
    fm_saddle[n] = '0;
    fm_height[n] = 0;
  endfunction

  function automatic void hang_edge(int unsigned a, int unsigned b,
                                    logic [SW-1:0] sid, longint h);
    reroot(a);
    fm_parent[a] = PW'(b);
    fm_saddle[a] = sid;
    fm_height[a] = h;
  endfunction

  function automatic sfei_pkg::out_beat_t insert_edge(sfei_pkg::in_beat_t bt);
    sfei_pkg::out_beat_t r;
    int unsigned a = 32'(bt.first_peak);
    int unsigned b = 32'(bt.second_peak);
    longint h = longint'(bt.new_saddle_height);
    int unsigned top, l1, l2, low;
    r.outcome = sfei_pkg::OC_DISCARD;
    r.dropped_saddle_id = bt.new_saddle_id;
    if (a == 0 || b == 0 || a == b) return r;
    top = common_ancestor(a, b);
    if (top == 0) begin
      hang_edge(a, b, bt.new_saddle_id, h);
      r.outcome = sfei_pkg::OC_LINKED;
      r.dropped_saddle_id = '0;
      return r;
    end
    l1 = weakest_edge(a, top);
    l2 = weakest_edge(b, top);
    if (l1 == 0) begin
      l1 = l2;
      l2 = 0;
    end
    if (l1 == 0) return r;
    low = l1;
    if (l2 != 0 && fm_height[l2] < fm_height[l1]) low = l2;
    if (h < fm_height[low]) return r;
    r.outcome = sfei_pkg::OC_REPLACED;
    r.dropped_saddle_id = fm_saddle[low];
    fm_parent[low] = '0;
    fm_saddle[low] = '0;
    fm_height[low] = 0;
    hang_edge(a, b, bt.new_saddle_id, h);
    return r;
  endfunction

  function automatic void add_row(int unsigned a, int unsigned b, int unsigned sid,
                                  logic signed [HW-1:0] h, bit typed,
                                  sfei_pkg::outcome_e oc, int unsigned dsid);
    row_t rw;
    rw.beat.first_peak = PW'(a);
    rw.beat.second_peak = PW'(b);
    rw.beat.new_saddle_id = SW'(sid);
    rw.beat.new_saddle_height = h;
    rw.typed = typed;
    rw.res.outcome = oc;
    rw.res.dropped_saddle_id = SW'(dsid);
    dir_rows = {dir_rows, rw};
  endfunction

  function automatic sfei_pkg::in_beat_t random_insert();
    sfei_pkg::in_beat_t bt;
    int unsigned sel = $urandom_range(99);
    int unsigned span = ($urandom_range(3) == 0) ? 40 : 12;
    if (sel < 80) begin
      // edge among a small cluster of peaks (the two may be equal)
      bt.first_peak = PW'($urandom_range(span, 1));
      bt.second_peak = PW'($urandom_range(span, 1));
    end else if (sel < 92) begin
      bt.first_peak = PW'($urandom_range(NumPeaks - 1, 1));
      bt.second_peak = PW'($urandom_range(NumPeaks - 1, 1));
    end else begin
      // noise: zero or equal peaks
      bt.first_peak = PW'($urandom);
      bt.second_peak = ($urandom_range(1)) ? bt.first_peak : '0;
    end
    bt.new_saddle_id = SW'($urandom);
    case ($urandom_range(3))
      0: bt.new_saddle_height = $urandom;
      1: bt.new_saddle_height = $signed($urandom_range(6)) - 3;
      2: bt.new_saddle_height = ($urandom_range(1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: bt.new_saddle_height = $signed($urandom_range(2000)) - 1000;
    endcase
    return bt;
  endfunction

  // one input beat, sometimes after a random gap
  task automatic send_beat(sfei_pkg::in_beat_t bt, bit typed,
                           sfei_pkg::out_beat_t typed_res);
    sfei_pkg::out_beat_t pr;
    int gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= bt;
    do @(posedge clk_i); while (!in_ready_o);
    pr = insert_edge(bt);
    pending_results = {pending_results, (typed ? typed_res : pr)};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // receiver ready, with a long hold-off on request
  initial begin
    int hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    sfei_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: outcome %0d sid %0d",
                   out_beat_o.outcome, out_beat_o.dropped_saddle_id);
      end else begin
        want = pending_results.pop_front();
        if (out_beat_o.outcome !== want.outcome ||
            out_beat_o.dropped_saddle_id !== want.dropped_saddle_id) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: expected outcome %0d sid %0d, got %0d sid %0d",
                     want.outcome, want.dropped_saddle_id,
                     out_beat_o.outcome, out_beat_o.dropped_saddle_id);
        end
      end
    end
  end

  // stimulus
  initial begin
    sfei_pkg::out_beat_t none;
    none = '0;
    for (int i = 0; i < NumPeaks; i++) begin
      fm_parent[i] = '0;
      fm_saddle[i] = '0;
      fm_height[i] = 0;
    end
    add_row(1, 2, 5, 100, 1, sfei_pkg::OC_LINKED, 0);
    add_row(2, 3, 6, -5, 1, sfei_pkg::OC_LINKED, 0);
    add_row(3, 1, 7, -10, 0, sfei_pkg::OC_DISCARD, 0);
    add_row(5, 5, 9, 0, 1, sfei_pkg::OC_DISCARD, 9);
    add_row(0, 4, 10, 0, 1, sfei_pkg::OC_DISCARD, 10);
    add_row(4, 0, 11, 0, 1, sfei_pkg::OC_DISCARD, 11);
    add_row(1023, 1, 4095, 32'sh7fff_ffff, 1, sfei_pkg::OC_LINKED, 0);
    add_row(1022, 1023, 0, 32'sh8000_0000, 1, sfei_pkg::OC_LINKED, 0);
    // tie at the lowest height
    add_row(1, 1022, 12, 32'sh8000_0000, 0, sfei_pkg::OC_DISCARD, 0);
    add_row(3, 1, 13, 32'sh7fff_ffff, 0, sfei_pkg::OC_DISCARD, 0);
    add_row(1023, 3, 4095, 100, 0, sfei_pkg::OC_DISCARD, 0);
    add_row(2, 1022, 0, -5, 0, sfei_pkg::OC_DISCARD, 0);
    add_row(0, 0, 0, 0, 1, sfei_pkg::OC_DISCARD, 0);
    add_row(1023, 1023, 4095, 32'sh8000_0000, 1, sfei_pkg::OC_DISCARD, 4095);
    add_row(1023, 0, 4095, 32'sh7fff_ffff, 1, sfei_pkg::OC_DISCARD, 4095);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 36 : 0;
      for (int i = 0; i < RandItems / 3; i++) begin
        if (ph == 1 && i == 100) hold_req = 1'b1;
        send_beat(random_insert(), 1'b0, none);
      end
      // sender waits for every result before the next phase
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
